@@ sv/hdamx_pkg.sv @@
// Shared types and constants for the HID descriptor axis maximum extractor.
package hdamx_pkg;

   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned VALUE_W = 32;
   localparam int unsigned CSR_W   = 16;
   localparam int unsigned RSP_W   = 72;

   typedef enum logic [1:0] {
      CSR_TARGET_REPORT = 2'd0,
      CSR_TARGET_PAGE   = 2'd1,
      CSR_USAGE_FOR_X   = 2'd2,
      CSR_USAGE_FOR_Y   = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      ITEM_MAIN     = 2'd0,
      ITEM_GLOBAL   = 2'd1,
      ITEM_LOCAL    = 2'd2,
      ITEM_RESERVED = 2'd3
   } item_kind_type;

   localparam logic [1:0] SIZE_CODE_FOUR = 2'd3;
   localparam logic [2:0] SIZE_FOUR      = 3'd4;
   localparam logic [2:0] SIZE_ONE       = 3'd1;
   localparam logic [2:0] SIZE_TWO       = 3'd2;

   localparam logic [3:0] TAG_USAGE_PAGE = 4'h0;
   localparam logic [3:0] TAG_LOGICAL_MAX = 4'h2;
   localparam logic [3:0] TAG_REPORT_ID  = 4'h8;
   localparam logic [3:0] TAG_USAGE      = 4'h0;

   localparam logic [7:0]  RESET_TARGET_REPORT = 8'h04;
   localparam logic [15:0] RESET_TARGET_PAGE   = 16'h0001;
   localparam logic [7:0]  RESET_USAGE_FOR_X   = 8'h30;
   localparam logic [7:0]  RESET_USAGE_FOR_Y   = 8'h31;

   typedef struct packed {
      logic         status;
      logic         y_found;
      logic         x_found;
      logic [31:0]  y_maximum;
      logic [31:0]  x_maximum;
   } result_type;

endpackage

@@ sv/hid_descriptor_axis_max_extract.sv @@
// HID report descriptor parser that extracts the X and Y logical maximum values.
//
// Descriptor bytes arrive one per transfer on req_ (tlast marks the final byte) and
// are decoded as short items in a single pass: one byte per clock cycle unless
// stalled, with the item decode, data shift-in and global/local update done between
// the byte input and the state registers. A result transfer appears on rsp_ from an
// output register the cycle after the byte that completes both axes, or after the
// last byte; req_tready is high whenever that register is empty or being drained.
// Bytes following an early result are consumed silently until tlast, which clears
// the parse state for the next descriptor. csr_ writes set the target report ID,
// usage page and axis usage codes and must only be made while idle (not enforced).
module hid_descriptor_axis_max_extract (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] descriptor_byte
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,   // [31:0] x_maximum, [63:32] y_maximum, [64] x_found,
                                    // [65] y_found, [66] status, [71:67] zero
   input  logic        csr_we,
   input  logic [1:0]  csr_addr,
   input  logic [15:0] csr_wdata
);

   logic [7:0]  target_report_ff;
   logic [15:0] target_page_ff;
   logic [7:0]  usage_for_x_ff;
   logic [7:0]  usage_for_y_ff;

   logic        in_item_ff, in_item_in;
   logic [2:0]  item_size_ff, item_size_in;
   logic [1:0]  item_type_ff, item_type_in;
   logic [3:0]  item_tag_ff, item_tag_in;
   logic [2:0]  bytes_taken_ff, bytes_taken_in;
   logic [31:0] data_accum_ff, data_accum_in;
   logic [31:0] page_ff, page_in;
   logic [31:0] report_ff, report_in;
   logic [31:0] logical_max_ff, logical_max_in;
   logic        x_seen_ff, x_seen_in;
   logic        y_seen_ff, y_seen_in;
   logic [31:0] x_value_ff, x_value_in;
   logic [31:0] y_value_ff, y_value_in;
   logic        result_sent_ff, result_sent_in;

   logic        rsp_valid_ff, rsp_valid_in;
   hdamx_pkg::result_type rsp_data_ff, rsp_data_in;

   logic        accept;
   logic        emit;
   logic        item_done;
   logic [2:0]  bytes_next;
   logic [31:0] data_new;
   logic [31:0] data_ext;
   logic [2:0]  size_code;
   logic        usage_hit;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'd0, rsp_data_ff};

   always_comb begin
      in_item_in     = in_item_ff;
      item_size_in   = item_size_ff;
      item_type_in   = item_type_ff;
      item_tag_in    = item_tag_ff;
      bytes_taken_in = bytes_taken_ff;
      data_accum_in  = data_accum_ff;
      page_in        = page_ff;
      report_in      = report_ff;
      logical_max_in = logical_max_ff;
      x_seen_in      = x_seen_ff;
      y_seen_in      = y_seen_ff;
      x_value_in     = x_value_ff;
      y_value_in     = y_value_ff;
      result_sent_in = result_sent_ff;
      emit           = 1'b0;
      item_done      = 1'b0;
      bytes_next     = 3'd0;
      data_new       = 32'd0;
      data_ext       = 32'd0;
      size_code      = 3'd0;
      usage_hit      = 1'b0;

      if (!in_item_ff) begin
         size_code = (req_tdata[1:0] == hdamx_pkg::SIZE_CODE_FOUR) ?
                     hdamx_pkg::SIZE_FOUR : {1'b0, req_tdata[1:0]};
         item_size_in   = size_code;
         item_type_in   = req_tdata[3:2];
         item_tag_in    = req_tdata[7:4];
         bytes_next     = 3'd0;
         data_new       = 32'd0;
         item_done      = (size_code == 3'd0);
         in_item_in     = (size_code != 3'd0);
      end else begin
         data_new   = data_accum_ff | ({24'd0, req_tdata} << {bytes_taken_ff[1:0], 3'b000});
         bytes_next = bytes_taken_ff + 3'd1;
         item_done  = (bytes_next >= item_size_ff);
      end
      bytes_taken_in = bytes_next;
      data_accum_in  = data_new;

      case (item_size_in)
         hdamx_pkg::SIZE_ONE: data_ext = {{24{data_new[7]}}, data_new[7:0]};
         hdamx_pkg::SIZE_TWO: data_ext = {{16{data_new[15]}}, data_new[15:0]};
         default:             data_ext = data_new;
      endcase

      if (item_done || req_tlast) begin
         if (item_type_in == hdamx_pkg::ITEM_GLOBAL) begin
            case (item_tag_in)
               hdamx_pkg::TAG_USAGE_PAGE:  page_in        = data_new;
               hdamx_pkg::TAG_LOGICAL_MAX: logical_max_in = data_ext;
               hdamx_pkg::TAG_REPORT_ID:   report_in      = data_new;
               default: ;
            endcase
         end else if (item_type_in == hdamx_pkg::ITEM_LOCAL &&
                      item_tag_in == hdamx_pkg::TAG_USAGE) begin
            usage_hit = (report_ff == {24'd0, target_report_ff}) &&
                        (page_ff == {16'd0, target_page_ff});
            if (usage_hit) begin
               if (data_new == {24'd0, usage_for_x_ff} && !x_seen_ff) begin
                  x_value_in = logical_max_ff;
                  x_seen_in  = 1'b1;
               end else if (data_new == {24'd0, usage_for_y_ff} && !y_seen_ff) begin
                  y_value_in = logical_max_ff;
                  y_seen_in  = 1'b1;
               end
            end
         end
         in_item_in     = 1'b0;
         bytes_taken_in = 3'd0;
         data_accum_in  = 32'd0;
      end

      if (req_tlast) begin
         emit = 1'b1;
      end else if (x_seen_in && y_seen_in) begin
         emit           = 1'b1;
         result_sent_in = 1'b1;
      end

      rsp_data_in.x_maximum = x_value_in;
      rsp_data_in.y_maximum = y_value_in;
      rsp_data_in.x_found   = x_seen_in;
      rsp_data_in.y_found   = y_seen_in;
      rsp_data_in.status    = !(x_seen_in && y_seen_in);

      if (result_sent_ff) begin
         emit           = 1'b0;
         in_item_in     = in_item_ff;
         item_size_in   = item_size_ff;
         item_type_in   = item_type_ff;
         item_tag_in    = item_tag_ff;
         bytes_taken_in = bytes_taken_ff;
         data_accum_in  = data_accum_ff;
         page_in        = page_ff;
         report_in      = report_ff;
         logical_max_in = logical_max_ff;
         x_seen_in      = x_seen_ff;
         y_seen_in      = y_seen_ff;
         x_value_in     = x_value_ff;
         y_value_in     = y_value_ff;
      end

      if (req_tlast) begin
         in_item_in     = 1'b0;
         item_size_in   = 3'd0;
         item_type_in   = 2'd0;
         item_tag_in    = 4'd0;
         bytes_taken_in = 3'd0;
         data_accum_in  = 32'd0;
         page_in        = 32'd0;
         report_in      = 32'd0;
         logical_max_in = 32'd0;
         x_seen_in      = 1'b0;
         y_seen_in      = 1'b0;
         x_value_in     = 32'd0;
         y_value_in     = 32'd0;
         result_sent_in = 1'b0;
      end

      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if (accept && emit) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         target_report_ff <= hdamx_pkg::RESET_TARGET_REPORT;
         target_page_ff   <= hdamx_pkg::RESET_TARGET_PAGE;
         usage_for_x_ff   <= hdamx_pkg::RESET_USAGE_FOR_X;
         usage_for_y_ff   <= hdamx_pkg::RESET_USAGE_FOR_Y;
      end else if (csr_we) begin
         case (hdamx_pkg::csr_index_type'(csr_addr))
            hdamx_pkg::CSR_TARGET_REPORT: target_report_ff <= csr_wdata[7:0];
            hdamx_pkg::CSR_TARGET_PAGE:   target_page_ff   <= csr_wdata;
            hdamx_pkg::CSR_USAGE_FOR_X:   usage_for_x_ff   <= csr_wdata[7:0];
            hdamx_pkg::CSR_USAGE_FOR_Y:   usage_for_y_ff   <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_item_ff     <= 1'b0;
         item_size_ff   <= 3'd0;
         item_type_ff   <= 2'd0;
         item_tag_ff    <= 4'd0;
         bytes_taken_ff <= 3'd0;
         data_accum_ff  <= 32'd0;
         page_ff        <= 32'd0;
         report_ff      <= 32'd0;
         logical_max_ff <= 32'd0;
         x_seen_ff      <= 1'b0;
         y_seen_ff      <= 1'b0;
         x_value_ff     <= 32'd0;
         y_value_ff     <= 32'd0;
         result_sent_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            in_item_ff     <= in_item_in;
            item_size_ff   <= item_size_in;
            item_type_ff   <= item_type_in;
            item_tag_ff    <= item_tag_in;
            bytes_taken_ff <= bytes_taken_in;
            data_accum_ff  <= data_accum_in;
            page_ff        <= page_in;
            report_ff      <= report_in;
            logical_max_ff <= logical_max_in;
            x_seen_ff      <= x_seen_in;
            y_seen_ff      <= y_seen_in;
            x_value_ff     <= x_value_in;
            y_value_ff     <= y_value_in;
            result_sent_ff <= result_sent_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept && emit) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   a_sent_needs_both: assert property (@(posedge clock) disable iff (reset)
      result_sent_ff |-> (x_seen_ff && y_seen_ff))
      else $error("early result flag set without both axes");

   a_status_matches: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff.status == !(rsp_data_ff.x_found && rsp_data_ff.y_found)))
      else $error("status disagrees with found flags");

   a_item_count: assert property (@(posedge clock) disable iff (reset)
      in_item_ff |-> (bytes_taken_ff < item_size_ff))
      else $error("data byte count overran item size");

   a_header_clean: assert property (@(posedge clock) disable iff (reset)
      !in_item_ff |-> (bytes_taken_ff == 3'd0 && data_accum_ff == 32'd0))
      else $error("accumulator not cleared between items");

   a_missing_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_data_ff.x_found) |-> (rsp_data_ff.x_maximum == 32'd0))
      else $error("x maximum nonzero without x found");

endmodule

@@ tb/hid_descriptor_axis_max_extract_test.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the HID descriptor axis maximum extractor.
module hid_descriptor_axis_max_extract_test;

   localparam int CYCLE_LIMIT = 400000;
   localparam logic [1:0] SIZE_CODE_NONE = 2'd0;
   localparam logic [1:0] SIZE_CODE_ONE  = 2'd1;
   localparam logic [1:0] SIZE_CODE_TWO  = 2'd2;

   logic        clock;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = '0;   // [7:0] descriptor_byte
   logic        req_tlast  = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [71:0] rsp_tdata;         // [31:0] x_maximum, [63:32] y_maximum, [64] x_found,
                                   // [65] y_found, [66] status, [71:67] zero
   logic        csr_we     = 1'b0;
   logic [1:0]  csr_addr   = '0;
   logic [15:0] csr_wdata  = '0;

   hid_descriptor_axis_max_extract u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // register copies
   logic [7:0]  cfg_report  = hdamx_pkg::RESET_TARGET_REPORT;
   logic [15:0] cfg_page    = hdamx_pkg::RESET_TARGET_PAGE;
   logic [7:0]  cfg_usage_x = hdamx_pkg::RESET_USAGE_FOR_X;
   logic [7:0]  cfg_usage_y = hdamx_pkg::RESET_USAGE_FOR_Y;

   // parser state mirror
   logic                     pr_in_data = 1'b0;
   logic [2:0]               pr_size    = '0;
   hdamx_pkg::item_kind_type pr_kind    = hdamx_pkg::ITEM_MAIN;
   logic [3:0]               pr_tag     = '0;
   logic [2:0]               pr_taken   = '0;
   logic [31:0]              pr_accum   = '0;
   logic [31:0]              pr_page    = '0;
   logic [31:0]              pr_report  = '0;
   logic [31:0]              pr_lmax    = '0;
   logic                     pr_x_seen  = 1'b0;
   logic                     pr_y_seen  = 1'b0;
   logic [31:0]              pr_x_value = '0;
   logic [31:0]              pr_y_value = '0;
   logic                     pr_sent    = 1'b0;

   hdamx_pkg::result_type axis_results_due[$];
   logic [7:0] desc_bytes[$];

   int sender_idle_pct  = 0;
   int rsp_stall_pct    = 0;
   int hold_cycles      = 0;
   int cycle_count      = 0;
   int mismatches       = 0;
   int bytes_sent       = 0;
   int descriptors_sent = 0;
   int results_checked  = 0;
   int settings_applied = 0;

   function void clear_parse();
      pr_in_data = 1'b0;
      pr_size    = '0;
      pr_kind    = hdamx_pkg::ITEM_MAIN;
      pr_tag     = '0;
      pr_taken   = '0;
      pr_accum   = '0;
      pr_page    = '0;
      pr_report  = '0;
      pr_lmax    = '0;
      pr_x_seen  = 1'b0;
      pr_y_seen  = 1'b0;
      pr_x_value = '0;
      pr_y_value = '0;
      pr_sent    = 1'b0;
   endfunction

   function void close_item();
      logic [31:0] d;
      d = pr_accum;
      if (pr_kind == hdamx_pkg::ITEM_GLOBAL) begin
         if (pr_tag == hdamx_pkg::TAG_USAGE_PAGE) begin
            pr_page = d;
         end else if (pr_tag == hdamx_pkg::TAG_LOGICAL_MAX) begin
            if (pr_size == hdamx_pkg::SIZE_ONE) d = {{24{d[7]}}, d[7:0]};
            else if (pr_size == hdamx_pkg::SIZE_TWO) d = {{16{d[15]}}, d[15:0]};
            pr_lmax = d;
         end else if (pr_tag == hdamx_pkg::TAG_REPORT_ID) begin
            pr_report = d;
         end
      end else if (pr_kind == hdamx_pkg::ITEM_LOCAL && pr_tag == hdamx_pkg::TAG_USAGE) begin
         if (pr_report == {24'd0, cfg_report} && pr_page == {16'd0, cfg_page}) begin
            if (d == {24'd0, cfg_usage_x} && !pr_x_seen) begin
               pr_x_value = pr_lmax;
               pr_x_seen  = 1'b1;
            end else if (d == {24'd0, cfg_usage_y} && !pr_y_seen) begin
               pr_y_value = pr_lmax;
               pr_y_seen  = 1'b1;
            end
         end
      end
      pr_in_data = 1'b0;
      pr_taken   = '0;
      pr_accum   = '0;
   endfunction

   function void post_axis_result();
      hdamx_pkg::result_type r;
      r.x_maximum = pr_x_seen ? pr_x_value : 32'd0;
      r.y_maximum = pr_y_seen ? pr_y_value : 32'd0;
      r.x_found   = pr_x_seen;
      r.y_found   = pr_y_seen;
      r.status    = !(pr_x_seen && pr_y_seen);
      axis_results_due.push_back(r);
   endfunction

   function void parse_descriptor_byte(logic [7:0] b, logic last);
      logic done;
      done = 1'b0;
      if (pr_sent) begin
         if (last) clear_parse();
         return;
      end
      if (!pr_in_data) begin
         pr_size  = (b[1:0] == hdamx_pkg::SIZE_CODE_FOUR) ?
                    hdamx_pkg::SIZE_FOUR : {1'b0, b[1:0]};
         pr_kind  = hdamx_pkg::item_kind_type'(b[3:2]);
         pr_tag   = b[7:4];
         pr_taken = '0;
         pr_accum = '0;
         if (pr_size == 3'd0) done = 1'b1;
         else pr_in_data = 1'b1;
      end else begin
         pr_accum = pr_accum | ({24'd0, b} << {pr_taken[1:0], 3'b000});
         pr_taken = pr_taken + 3'd1;
         if (pr_taken >= pr_size) done = 1'b1;
      end
      if (done || last) close_item();
      if (last) begin
         post_axis_result();
         clear_parse();
      end else if (pr_x_seen && pr_y_seen) begin
         post_axis_result();
         pr_sent = 1'b1;
      end
   endfunction

   task automatic note_mismatch(string field, logic [31:0] want, logic [31:0] got);
      mismatches++;
      if (mismatches <= 10)
         $display("[%0t] mismatch %s: expected %h, got %h", $realtime, field, want, got);
   endtask

   always @(posedge clock) begin : result_check
      hdamx_pkg::result_type got;
      hdamx_pkg::result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata[$bits(hdamx_pkg::result_type)-1:0];
         if (axis_results_due.size() == 0) begin
            note_mismatch("unexpected result", 32'd0, got.x_maximum);
         end else begin
            want = axis_results_due.pop_front();
            results_checked++;
            if (got.x_maximum !== want.x_maximum)
               note_mismatch("x_maximum", want.x_maximum, got.x_maximum);
            if (got.y_maximum !== want.y_maximum)
               note_mismatch("y_maximum", want.y_maximum, got.y_maximum);
            if (got.x_found !== want.x_found)
               note_mismatch("x_found", 32'(want.x_found), 32'(got.x_found));
            if (got.y_found !== want.y_found)
               note_mismatch("y_found", 32'(want.y_found), 32'(got.y_found));
            if (got.status !== want.status)
               note_mismatch("status", 32'(want.status), 32'(got.status));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                  axis_results_due.size());
         $display("Regression FAIL");
         $finish;
      end
   end

   // result side: random stalls, or a counted hold-off when requested
   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         hold_cycles = hold_cycles - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   task send_byte(input logic [7:0] b, input logic last);
      while ($urandom_range(99) < sender_idle_pct) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      parse_descriptor_byte(b, last);
      bytes_sent++;
   endtask

   task send_descriptor();
      for (int i = 0; i < desc_bytes.size(); i++)
         send_byte(desc_bytes[i], i == desc_bytes.size() - 1);
      desc_bytes.delete();
      descriptors_sent++;
   endtask

   task wait_idle(input int settle);
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (axis_results_due.size() != 0) @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   task write_register(input hdamx_pkg::csr_index_type idx, input logic [15:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      case (idx)
         hdamx_pkg::CSR_TARGET_REPORT: cfg_report  = value[7:0];
         hdamx_pkg::CSR_TARGET_PAGE:   cfg_page    = value;
         hdamx_pkg::CSR_USAGE_FOR_X:   cfg_usage_x = value[7:0];
         default:                      cfg_usage_y = value[7:0];
      endcase
   endtask

   // upper byte of the 8-bit registers carries junk that must be dropped
   task apply_setting(input logic [7:0] report, input logic [15:0] page,
                      input logic [7:0] ux, input logic [7:0] uy);
      logic [7:0] junk;
      wait_idle(4);
      junk = 8'($urandom_range(255));
      write_register(hdamx_pkg::CSR_TARGET_REPORT, {junk, report});
      write_register(hdamx_pkg::CSR_TARGET_PAGE, page);
      junk = 8'($urandom_range(255));
      write_register(hdamx_pkg::CSR_USAGE_FOR_X, {junk, ux});
      junk = 8'($urandom_range(255));
      write_register(hdamx_pkg::CSR_USAGE_FOR_Y, {junk, uy});
      settings_applied++;
   endtask

   task set_idling(input int sender_pct, input int receiver_pct);
      sender_idle_pct = sender_pct;
      rsp_stall_pct   = receiver_pct;
   endtask

   function void add_item(logic [3:0] tag, hdamx_pkg::item_kind_type kind, logic [1:0] code,
                          logic [31:0] value);
      int n;
      n = (code == hdamx_pkg::SIZE_CODE_FOUR) ? 4 : int'(code);
      desc_bytes.push_back({tag, kind, code});
      for (int i = 0; i < n; i++) desc_bytes.push_back(value[8*i +: 8]);
   endfunction

   function logic [1:0] fit_code(logic [31:0] v);
      if ($urandom_range(3) == 0) return hdamx_pkg::SIZE_CODE_FOUR;
      if (v[31:16] != 16'd0) return hdamx_pkg::SIZE_CODE_FOUR;
      if (v[15:8] != 8'd0) return SIZE_CODE_TWO;
      if (v[7:0] != 8'd0) return SIZE_CODE_ONE;
      return ($urandom_range(1) == 0) ? SIZE_CODE_NONE : SIZE_CODE_ONE;
   endfunction

   function logic [31:0] near_value(logic [31:0] want);
      if ($urandom_range(99) < 80) return want;
      return ($urandom_range(1) == 0) ? $urandom : $urandom_range(255);
   endfunction

   function logic [31:0] lmax_value();
      case ($urandom_range(9))
         0: return 32'h0000_0000;
         1: return 32'h0000_007F;
         2: return 32'h0000_0080;
         3: return 32'h0000_8000;
         4: return 32'h7FFF_FFFF;
         5: return 32'h8000_0000;
         6: return 32'hFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   function logic [31:0] usage_value();
      int pick;
      pick = $urandom_range(99);
      if (pick < 40) return {24'd0, cfg_usage_x};
      if (pick < 80) return {24'd0, cfg_usage_y};
      if (pick < 95) return $urandom_range(255);
      return $urandom;
   endfunction

   task build_descriptor();
      int pick;
      int cut;
      logic [31:0] v;
      logic [7:0] hdr;
      if ($urandom_range(9) < 7) begin
         v = near_value({16'd0, cfg_page});
         add_item(hdamx_pkg::TAG_USAGE_PAGE, hdamx_pkg::ITEM_GLOBAL, fit_code(v), v);
         v = near_value({24'd0, cfg_report});
         add_item(hdamx_pkg::TAG_REPORT_ID, hdamx_pkg::ITEM_GLOBAL, fit_code(v), v);
      end
      repeat ($urandom_range(1, 7)) begin
         pick = $urandom_range(99);
         if (pick < 12) begin
            v = near_value({16'd0, cfg_page});
            add_item(hdamx_pkg::TAG_USAGE_PAGE, hdamx_pkg::ITEM_GLOBAL, fit_code(v), v);
         end else if (pick < 22) begin
            v = near_value({24'd0, cfg_report});
            add_item(hdamx_pkg::TAG_REPORT_ID, hdamx_pkg::ITEM_GLOBAL, fit_code(v), v);
         end else if (pick < 45) begin
            add_item(hdamx_pkg::TAG_LOGICAL_MAX, hdamx_pkg::ITEM_GLOBAL,
                     2'($urandom_range(3)), lmax_value());
         end else if (pick < 80) begin
            v = usage_value();
            add_item(hdamx_pkg::TAG_USAGE, hdamx_pkg::ITEM_LOCAL, fit_code(v), v);
         end else begin
            hdr = 8'($urandom_range(255));
            add_item(hdr[7:4], hdamx_pkg::item_kind_type'(hdr[3:2]), hdr[1:0], $urandom);
         end
      end
      // descriptor cut short at a random byte, possibly inside an item
      if ($urandom_range(99) < 15) begin
         cut = $urandom_range(1, desc_bytes.size());
         while (desc_bytes.size() > cut) void'(desc_bytes.pop_back());
      end
   endtask

   task run_random_phase(input int n_bytes);
      int start;
      start = bytes_sent;
      while (bytes_sent - start < n_bytes) begin
         build_descriptor();
         send_descriptor();
         if ($urandom_range(19) == 0) wait_idle(4);
      end
   endtask

   // both axes found early, then trailing bytes dropped until tlast
   task test_reference_descriptor();
      set_idling(0, 0);
      add_item(hdamx_pkg::TAG_USAGE_PAGE, hdamx_pkg::ITEM_GLOBAL, SIZE_CODE_ONE, 32'h01);
      add_item(hdamx_pkg::TAG_REPORT_ID, hdamx_pkg::ITEM_GLOBAL, SIZE_CODE_ONE, 32'h04);
      add_item(hdamx_pkg::TAG_LOGICAL_MAX, hdamx_pkg::ITEM_GLOBAL, SIZE_CODE_TWO, 32'h7FFF);
      add_item(hdamx_pkg::TAG_USAGE, hdamx_pkg::ITEM_LOCAL, SIZE_CODE_ONE, 32'h30);
      add_item(hdamx_pkg::TAG_LOGICAL_MAX, hdamx_pkg::ITEM_GLOBAL, SIZE_CODE_ONE, 32'h80);
      add_item(hdamx_pkg::TAG_USAGE, hdamx_pkg::ITEM_LOCAL, SIZE_CODE_ONE, 32'h31);
      desc_bytes.push_back(8'hFF);
      desc_bytes.push_back(8'hFF);
      send_descriptor();
   endtask

   // empty main item, long-item header, cut-short usage, lone sized header
   task test_truncated_items();
      desc_bytes = '{8'h00, 8'hFE, 8'h30, 8'h31, 8'h0A, 8'h30};
      send_descriptor();
      desc_bytes.push_back(8'h27);
      send_descriptor();
      wait_idle(4);
   endtask

   task test_register_extremes();
      set_idling(0, 0);
      run_random_phase(120);
      // same usage on both axes: first match goes to X, second to Y
      apply_setting(8'hFF, 16'hFFFF, 8'h00, 8'h00);
      set_idling(71, 0);
      run_random_phase(150);
      apply_setting(8'h00, 16'h0000, 8'hFF, 8'hFF);
      set_idling(0, 71);
      run_random_phase(150);
   endtask

   task test_random_settings();
      repeat (3) begin
         apply_setting(8'($urandom_range(255)), 16'($urandom_range(65535)),
                       8'($urandom_range(255)), 8'($urandom_range(255)));
         set_idling(16, 16);
         run_random_phase(70);
         set_idling(0, 0);
         run_random_phase(70);
      end
   endtask

   task test_output_backpressure();
      apply_setting(hdamx_pkg::RESET_TARGET_REPORT, hdamx_pkg::RESET_TARGET_PAGE,
                    hdamx_pkg::RESET_USAGE_FOR_X, hdamx_pkg::RESET_USAGE_FOR_Y);
      set_idling(0, 0);
      hold_cycles = 300;
      run_random_phase(100);
      wait_idle(4);
   endtask

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_reference_descriptor();
      test_truncated_items();
      test_register_extremes();
      test_random_settings();
      test_output_backpressure();
      wait_idle(8);
      $display("Sent %0d bytes in %0d descriptors under %0d register settings;",
               bytes_sent, descriptors_sent, settings_applied + 1);
      $display("checked %0d results, %0d mismatches", results_checked, mismatches);
      if (mismatches == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

@@ hid_descriptor_axis_max_extract.f @@
sv/hdamx_pkg.sv
sv/hid_descriptor_axis_max_extract.sv
tb/hid_descriptor_axis_max_extract_test.sv
